### rtl/sorted_interval_table_free_defines.svh
// Assertion macros shared by the interval table RTL.
`ifndef SORTED_INTERVAL_TABLE_FREE_DEFINES_SVH
`define SORTED_INTERVAL_TABLE_FREE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SITF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SITF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sitf_pkg.sv
// Types, codes and defaults shared by the interval table modules.
`default_nettype none

package sitf_pkg;

  localparam int unsigned POOL_BYTES_DEF = 65536;
  localparam int unsigned MAX_BLOCKS_DEF = 256;

  typedef enum logic [2:0] {
    ST_FREED    = 3'd0,
    ST_NOMATCH  = 3'd1,
    ST_OUTSIDE  = 3'd2,
    ST_APPENDED = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_FREE   = 1'b1;

  typedef struct packed {
    logic        func;
    logic [19:0] offset;
    logic [15:0] range_end;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  slot;
    logic [8:0]  entries;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic    ld_req;
    logic    srch_init;
    logic    srch_rd;
    logic    go_hi;
    logic    go_lo;
    logic    take_hit;
    logic    shift_step;
    logic    fin;
    status_t fin_status;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic outside;
    logic is_free;
    logic full;
    logic empty;
    logic srch_open;
    logic hit;
    logic go_low;
    logic shift_more;
  } sts_t;

endpackage

`default_nettype wire

### rtl/sitf_dp.sv
// Datapath: request register, table memory, search bounds and shift pointer.
`default_nettype none

module sitf_dp #(
  parameter int unsigned POOL_BYTES = sitf_pkg::POOL_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS = sitf_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire sitf_pkg::req_t in_req,
  input  wire sitf_pkg::cmd_t cmd,
  output sitf_pkg::sts_t      sts,
  output sitf_pkg::rsp_t      out_rsp
);
  import sitf_pkg::*;

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [20:0] POOL_LIM = 21'(POOL_BYTES);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

  typedef struct packed {
    logic [15:0] b_start;
    logic [15:0] b_end;
  } ent_t;

  ent_t          mem [MAX_BLOCKS];
  ent_t          rdata_r;
  req_t          req_r;
  rsp_t          out_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] lo_r;
  logic [CW-1:0] hip_r;
  logic [IW-1:0] mid_r;
  logic [IW-1:0] ptr_r;
  logic [IW-1:0] pos_r;
  logic [IW-1:0] wptr_r;
  logic          wpend_r;
  logic [CW:0]   msum;
  logic [IW-1:0] mid_c;
  logic [IW-1:0] raddr;
  logic          rd_en;
  logic [CW:0]   ptr_inc;
  logic [19:0]   s_ext;
  logic [19:0]   e_ext;
  logic [IW+7:0] pos_w;
  logic [IW+7:0] cnt_w;
  logic [CW+8:0] ent_w;
  logic          do_append;
  logic          do_free;

  // hip_r holds the upper search bound plus one, so it never goes negative.
  assign msum  = {1'b0, lo_r} + {1'b0, hip_r} - (CW+1)'(1);
  assign mid_c = msum[IW:1];

  assign ptr_inc = (CW+1)'(ptr_r) + (CW+1)'(1);

  assign rd_en = cmd.srch_rd | cmd.shift_step;
  assign raddr = cmd.srch_rd ? mid_c : ptr_inc[IW-1:0];

  assign s_ext = {4'b0, rdata_r.b_start};
  assign e_ext = {4'b0, rdata_r.b_end};

  assign do_append = cmd.fin && (cmd.fin_status == ST_APPENDED);
  assign do_free   = cmd.fin && (cmd.fin_status == ST_FREED);

  always_comb begin
    count_nxt = count_r;
    if (do_append) begin
      count_nxt = count_r + CW'(1);
    end else if (do_free) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign pos_w = {8'b0, pos_r};
  assign cnt_w = {8'b0, count_r[IW-1:0]};
  assign ent_w = {9'b0, count_nxt};

  assign sts.outside    = ({1'b0, req_r.offset} >= POOL_LIM);
  assign sts.is_free    = (req_r.func == FUNC_FREE);
  assign sts.full       = (count_r >= CNT_MAX);
  assign sts.empty      = (count_r == '0);
  assign sts.srch_open  = (lo_r < hip_r);
  assign sts.hit        = (s_ext <= req_r.offset) && (e_ext >= req_r.offset);
  assign sts.go_low     = (s_ext > req_r.offset);
  assign sts.shift_more = (ptr_inc < (CW+1)'(count_r));

  assign out_rsp = out_r;

  // Table memory: one read port with registered data, one write port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
    if (do_append) begin
      mem[count_r[IW-1:0]] <= '{b_start: req_r.offset[15:0], b_end: req_r.range_end};
    end else if (wpend_r) begin
      mem[wptr_r] <= rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      wpend_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      wpend_r <= cmd.shift_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      req_r <= in_req;
    end
    if (cmd.srch_init) begin
      lo_r  <= '0;
      hip_r <= count_r;
    end
    if (cmd.srch_rd) begin
      mid_r <= mid_c;
    end
    if (cmd.go_hi) begin
      hip_r <= CW'(mid_r);
    end
    if (cmd.go_lo) begin
      lo_r <= CW'(mid_r) + CW'(1);
    end
    if (cmd.take_hit) begin
      pos_r <= mid_r;
      ptr_r <= mid_r;
    end
    if (cmd.shift_step) begin
      wptr_r <= ptr_r;
      ptr_r  <= ptr_inc[IW-1:0];
    end
    if (cmd.fin) begin
      out_r.status  <= cmd.fin_status;
      out_r.entries <= ent_w[8:0];
      if (do_append) begin
        out_r.slot <= cnt_w[7:0];
      end else if (do_free) begin
        out_r.slot <= pos_w[7:0];
      end else begin
        out_r.slot <= '0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/sitf_ctrl.sv
// Controller: sequences the check for each request, and binary search and shift-down for a free.
`default_nettype none

module sitf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire sitf_pkg::sts_t sts,
  output sitf_pkg::cmd_t      cmd,
  output logic                busy,
  output logic                out_valid
);
  import sitf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SRD,
    S_SCMP,
    S_SHIFT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;
  logic   strobe_r;

  always_comb begin
    cmd       = '0;
    cmd.fin_status = ST_NOMATCH;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.ld_req = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.outside) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ST_OUTSIDE;
          state_nxt      = S_IDLE;
        end else if (!sts.is_free) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = sts.full ? ST_FULL : ST_APPENDED;
          state_nxt      = S_IDLE;
        end else if (sts.empty) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ST_NOMATCH;
          state_nxt      = S_IDLE;
        end else begin
          cmd.srch_init = 1'b1;
          state_nxt     = S_SRD;
        end
      end
      S_SRD: begin
        if (sts.srch_open) begin
          cmd.srch_rd = 1'b1;
          state_nxt   = S_SCMP;
        end else begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ST_NOMATCH;
          state_nxt      = S_IDLE;
        end
      end
      S_SCMP: begin
        priority if (sts.hit) begin
          cmd.take_hit = 1'b1;
          state_nxt    = S_SHIFT;
        end else if (sts.go_low) begin
          cmd.go_hi = 1'b1;
          state_nxt = S_SRD;
        end else begin
          cmd.go_lo = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_SHIFT: begin
        if (sts.shift_more) begin
          cmd.shift_step = 1'b1;
        end else begin
          // The last moved entry is written back in this same cycle.
          cmd.fin        = 1'b1;
          cmd.fin_status = ST_FREED;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      busy_r   <= (state_nxt != S_IDLE);
      strobe_r <= cmd.fin;
    end
  end

  assign busy      = busy_r;
  assign out_valid = strobe_r;

endmodule

`default_nettype wire

### rtl/sorted_interval_table_free.sv
// Top level of the sorted interval table with append and binary-search free.
//
//   channel  ports                     taken when
//   input    start, busy, in_req       start high and busy low
//   output   out_valid, out_rsp        out_valid high, one cycle, no back-pressure
//
// One request is worked at a time; busy stays high from acceptance to the result.
// Out-of-pool, full-table, empty-table free and append requests finish in the check state.
// A free runs a binary search, a read and a compare per step, then moves each
// later entry down in turn through the single read port of the table memory.
// Reset clears the entry count and control state; the table needs no clearing pass.
`default_nettype none

`include "sorted_interval_table_free_defines.svh"

module sorted_interval_table_free #(
  parameter int unsigned POOL_BYTES = sitf_pkg::POOL_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS = sitf_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire sitf_pkg::req_t in_req,
  output logic                out_valid,
  output sitf_pkg::rsp_t      out_rsp
);
  import sitf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sitf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  sitf_dp #(
    .POOL_BYTES (POOL_BYTES),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .sts     (sts),
    .out_rsp (out_rsp)
  );

  `SITF_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "request accepted but not busy")
  `SITF_ASSERT_NEXT(a_one_result, clk, rst_n, out_valid, !out_valid, "back-to-back results")
  `SITF_ASSERT_IMPL(a_append_count, clk, rst_n, out_valid && out_rsp.status == ST_APPENDED, out_rsp.entries[7:0] == 8'(out_rsp.slot + 8'd1), "append count mismatch")
  `SITF_ASSERT_IMPL(a_slot_zero, clk, rst_n, out_valid && out_rsp.status != ST_FREED && out_rsp.status != ST_APPENDED, out_rsp.slot == 8'd0, "slot not zero")

endmodule

`default_nettype wire
